/* hw/rtl/cnb_pkg.sv */
`timescale 1ns / 1ps

package cnb_pkg;

    // Fixed field widths
    localparam int BURST_COUNT = 4;
    localparam int COEF_WIDTH_DEF = 24;
    localparam int ENV_W = 24;
    localparam int CNT_W = 17;
    localparam int SUM_W = 27;
    localparam int HIST_W = 32;
    localparam int MUL_A_W = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Fixed gains and limits
    localparam logic [14:0] ACCENT_GAIN = 15'd22938;
    localparam logic [15:0] BURST_WEIGHT = 16'd39322;
    localparam logic [14:0] TAIL_WEIGHT = 15'd19661;
    localparam logic [SUM_W-1:0] QUIET_LIMIT = SUM_W'(4);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [14:0] TANH_MAX = 15'd16373;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BANDPASS_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_DECAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_THIRD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_MAIN = 3'd7;

    // Register reset values
    localparam logic [21:0] RST_BANDPASS_GAIN = 22'd250000;
    localparam logic signed [23:0] RST_FEEDBACK_ONE = -24'sd7800000;
    localparam logic [23:0] RST_BURST_DECAY = 24'd16700000;
    localparam logic [23:0] RST_TAIL_DECAY = 24'd16770000;
    localparam logic [15:0] RST_OUTPUT_LEVEL = 16'd16384;
    localparam logic [15:0] RST_ONSET_SECOND = 16'd240;
    localparam logic [15:0] RST_ONSET_THIRD = 16'd480;
    localparam logic [15:0] RST_ONSET_MAIN = 16'd864;

    // Datapath operations; each product is registered and written back in the following cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_TRIG_MUL,
        OP_TRIG_ACC,
        OP_TRIG_SET,
        OP_WEIGHT,
        OP_FIRE,
        OP_DEC0,
        OP_DEC1,
        OP_DEC2,
        OP_DEC3,
        OP_TAILW,
        OP_TAILD,
        OP_NOISE,
        OP_FX2,
        OP_FY1,
        OP_FY2,
        OP_FX0,
        OP_FSAT,
        OP_YOUT,
        OP_TANH,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sounding;
    } status_t;

    function automatic op_t next_op(input op_t op);
        op_t r;
        r = OP_NONE;
        unique case (op)
            OP_TRIG_MUL: r = OP_TRIG_ACC;
            OP_TRIG_ACC: r = OP_TRIG_SET;
            OP_WEIGHT:   r = OP_FIRE;
            OP_FIRE:     r = OP_DEC0;
            OP_DEC0:     r = OP_DEC1;
            OP_DEC1:     r = OP_DEC2;
            OP_DEC2:     r = OP_DEC3;
            OP_DEC3:     r = OP_TAILW;
            OP_TAILW:    r = OP_TAILD;
            OP_TAILD:    r = OP_NOISE;
            OP_NOISE:    r = OP_FX2;
            OP_FX2:      r = OP_FY1;
            OP_FY1:      r = OP_FY2;
            OP_FY2:      r = OP_FX0;
            OP_FX0:      r = OP_FSAT;
            OP_FSAT:     r = OP_YOUT;
            OP_YOUT:     r = OP_TANH;
            OP_TANH:     r = OP_FINISH;
            default:     r = OP_NONE;
        endcase
        return r;
    endfunction

    // 16384 * tanh(k/4), k = 0..16
    function automatic logic [14:0] tanh_half(input logic [4:0] k);
        logic [14:0] r;
        r = TANH_MAX;
        unique case (k)
            5'd0:  r = 15'd0;
            5'd1:  r = 15'd4013;
            5'd2:  r = 15'd7571;
            5'd3:  r = 15'd10406;
            5'd4:  r = 15'd12478;
            5'd5:  r = 15'd13898;
            5'd6:  r = 15'd14830;
            5'd7:  r = 15'd15423;
            5'd8:  r = 15'd15795;
            5'd9:  r = 15'd16024;
            5'd10: r = 15'd16165;
            5'd11: r = 15'd16251;
            5'd12: r = 15'd16303;
            5'd13: r = 15'd16335;
            5'd14: r = 15'd16354;
            5'd15: r = 15'd16366;
            default: r = TANH_MAX;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/cnb_ctrl.sv */
`timescale 1ns / 1ps

module cnb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             func,
    output logic             in_stall,
    input  logic             out_stall,
    output logic             out_valid,
    input  cnb_pkg::status_t status,
    output cnb_pkg::cmd_t    cmd
);
    import cnb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.op   = op_reg;
    assign cmd.load = accept;
    assign cmd.emit = (state_reg == S_EMIT) && out_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func)
                    begin
                        state_next = S_BUSY;
                        op_next    = OP_TRIG_MUL;
                    end
                    else if (status.sounding)
                    begin
                        state_next = S_BUSY;
                        op_next    = OP_WEIGHT;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_BUSY:
            begin
                op_next = next_op(op_reg);
                if (op_reg == OP_TRIG_SET)
                begin
                    state_next = S_IDLE;
                end
                else if (op_reg == OP_FINISH)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                op_next    = OP_NONE;
            end
        endcase
    end

    // Output transfer flag
    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled one");

    a_trig_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func) |=> !cmd.emit ##1 !cmd.emit)
        else $error("trigger produced a result");

    a_finish_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUSY && op_reg == OP_FINISH) |=> state_reg == S_EMIT)
        else $error("tick finished without result");

    a_busy_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUSY) |-> op_reg != OP_NONE)
        else $error("busy without operation");

endmodule

/* hw/rtl/cnb_dp.sv */
`timescale 1ns / 1ps

module cnb_dp
#(
    parameter int COEF_WIDTH = cnb_pkg::COEF_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cnb_pkg::cmd_t                       cmd,
    output cnb_pkg::status_t                    status,
    input  logic                                func,
    input  logic [15:0]                         hit_velocity,
    input  logic                                accent,
    input  logic signed [15:0]                  noise_sample,
    input  logic                                cfg_we,
    input  logic [cnb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cnb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [15:0]                  audio_out,
    output logic                                voice_active
);
    import cnb_pkg::*;

    localparam int CF = COEF_WIDTH - 2;
    localparam int BW = ((COEF_WIDTH > 24) ? COEF_WIDTH : 24) + 2;
    localparam int PW = MUL_A_W + BW;
    localparam int AW = PW + 2;

    function automatic logic signed [HIST_W-1:0] sat32(input logic signed [AW-1:0] v);
        logic signed [HIST_W-1:0] r;
        if ((v[AW-1:HIST_W-1] == '0) || (v[AW-1:HIST_W-1] == '1))
            r = v[HIST_W-1:0];
        else if (v[AW-1])
            r = {1'b1, {(HIST_W-1){1'b0}}};
        else
            r = {1'b0, {(HIST_W-1){1'b1}}};
        return r;
    endfunction

    // Configuration registers
    logic [21:0]        gain_reg;
    logic signed [23:0] fb_reg;
    logic [23:0]        bdecay_reg, tdecay_reg;
    logic [15:0]        level_reg, onset2_reg, onset3_reg, onset4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= RST_BANDPASS_GAIN;
            fb_reg     <= RST_FEEDBACK_ONE;
            bdecay_reg <= RST_BURST_DECAY;
            tdecay_reg <= RST_TAIL_DECAY;
            level_reg  <= RST_OUTPUT_LEVEL;
            onset2_reg <= RST_ONSET_SECOND;
            onset3_reg <= RST_ONSET_THIRD;
            onset4_reg <= RST_ONSET_MAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BANDPASS_GAIN: gain_reg   <= cfg_data[21:0];
                REG_FEEDBACK_ONE:  fb_reg     <= $signed(cfg_data[23:0]);
                REG_BURST_DECAY:   bdecay_reg <= cfg_data[23:0];
                REG_TAIL_DECAY:    tdecay_reg <= cfg_data[23:0];
                REG_OUTPUT_LEVEL:  level_reg  <= cfg_data[15:0];
                REG_ONSET_SECOND:  onset2_reg <= cfg_data[15:0];
                REG_ONSET_THIRD:   onset3_reg <= cfg_data[15:0];
                REG_ONSET_MAIN:    onset4_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Voice state and working registers
    logic                     sounding_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [ENV_W-1:0]         vel_reg;
    logic [ENV_W-1:0]         burst_reg [BURST_COUNT];
    logic [ENV_W-1:0]         tail_reg;
    logic signed [HIST_W-1:0] hist_reg [4];
    logic [SUM_W-1:0]         sum_reg;
    logic signed [HIST_W-1:0] x0_reg, y0_reg;
    logic signed [AW-1:0]     acc_reg;
    logic [31:0]              p_reg;
    logic [15:0]              hv_reg;
    logic                     accent_reg;
    logic signed [15:0]       noise_reg;
    logic                     neg_reg, big_reg;
    logic [14:0]              base_reg;
    logic signed [15:0]       res_audio_reg;
    logic                     res_active_reg;
    logic signed [15:0]       audio_reg;
    logic                     active_reg;
    logic signed [PW-1:0]     prod_reg;
    op_t                      wb_op_reg;

    assign status.sounding = sounding_reg;
    assign audio_out       = audio_reg;
    assign voice_active    = active_reg;

    // Derived coefficients
    logic signed [BW-1:0] b0_ext, a1_ext, a2_ext;
    assign b0_ext = $signed({{(BW-22){1'b0}}, gain_reg});
    assign a1_ext = {{(BW-24){fb_reg[23]}}, fb_reg};
    assign a2_ext = (BW'(1) <<< CF) - {{(BW-23){1'b0}}, gain_reg, 1'b0};

    // tanh segment lookup
    logic [31:0] mag;
    logic [3:0]  seg;
    logic [14:0] seg_lo, seg_hi;
    assign mag    = y0_reg[HIST_W-1] ? (32'd0 - y0_reg) : y0_reg;
    assign seg    = mag[22:19];
    assign seg_lo = tanh_half({1'b0, seg});
    assign seg_hi = tanh_half(5'({1'b0, seg}) + 5'd1);

    // Shared multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [BW-1:0]      mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_TRIG_MUL:
            begin
                mul_a = MUL_A_W'(hv_reg);
                mul_b = BW'(level_reg);
            end
            OP_TRIG_ACC:
            begin
                // velocity times level is still in the product register
                mul_a = MUL_A_W'(prod_reg[31:0]);
                mul_b = BW'(ACCENT_GAIN);
            end
            OP_WEIGHT:
            begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = BW'(BURST_WEIGHT);
            end
            OP_DEC0, OP_DEC1, OP_DEC2, OP_DEC3:
            begin
                mul_a = MUL_A_W'(burst_reg[2'(cmd.op - OP_DEC0)]);
                mul_b = BW'(bdecay_reg);
            end
            OP_TAILW:
            begin
                mul_a = MUL_A_W'(tail_reg);
                mul_b = BW'(TAIL_WEIGHT);
            end
            OP_TAILD:
            begin
                mul_a = MUL_A_W'(tail_reg);
                mul_b = BW'(tdecay_reg);
            end
            OP_NOISE:
            begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = {{(BW-16){noise_reg[15]}}, noise_reg};
            end
            OP_FX2:
            begin
                mul_a = MUL_A_W'(hist_reg[1]);
                mul_b = b0_ext;
            end
            OP_FY1:
            begin
                mul_a = MUL_A_W'(hist_reg[2]);
                mul_b = a1_ext;
            end
            OP_FY2:
            begin
                mul_a = MUL_A_W'(hist_reg[3]);
                mul_b = a2_ext;
            end
            OP_FX0:
            begin
                mul_a = MUL_A_W'(x0_reg);
                mul_b = b0_ext;
            end
            OP_TANH:
            begin
                mul_a = MUL_A_W'(mag[18:0]);
                mul_b = BW'(seg_hi - seg_lo);
            end
            default: ;
        endcase
    end

    // Sign extension of the history taps into the multiplier operand
    // is handled by the signed size casts above.

    // Onset match and trigger velocity
    logic [BURST_COUNT-1:0] fire;
    logic [24:0]            vel_raw;
    logic [ENV_W-1:0]       vel_sat;
    logic signed [AW-1:0]   prod_ext;
    logic signed [AW-1:0]   y_shift;
    logic [CNT_W-1:0]       count_inc;
    logic [14:0]            tanh_mag;

    assign fire[0]   = (count_reg == '0);
    assign fire[1]   = (count_reg == CNT_W'(onset2_reg));
    assign fire[2]   = (count_reg == CNT_W'(onset3_reg));
    assign fire[3]   = (count_reg == CNT_W'(onset4_reg));
    assign vel_raw   = accent_reg ? prod_reg[46:22] : {1'b0, p_reg[31:8]};
    assign vel_sat   = vel_raw[24] ? '1 : vel_raw[23:0];
    assign prod_ext  = AW'(prod_reg);
    assign y_shift   = acc_reg >>> CF;
    assign count_inc = (count_reg < COUNT_MAX) ? (count_reg + 1'b1) : count_reg;
    assign tanh_mag  = base_reg + (big_reg ? 15'd0 : 15'(prod_reg[31:19]));

    // Multiplier and product register
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_op_reg    <= OP_NONE;
            sounding_reg <= 1'b0;
            count_reg    <= '0;
            vel_reg      <= '0;
            tail_reg     <= '0;
            for (int i = 0; i < BURST_COUNT; i++)
                burst_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            wb_op_reg <= cmd.op;

            // Trigger: latch velocity, restart the voice
            if (wb_op_reg == OP_TRIG_ACC)
            begin
                vel_reg      <= vel_sat;
                count_reg    <= '0;
                sounding_reg <= 1'b1;
                tail_reg     <= '0;
                for (int i = 0; i < BURST_COUNT; i++)
                    burst_reg[i] <= '0;
                for (int i = 0; i < 4; i++)
                    hist_reg[i] <= '0;
            end

            // Burst onsets
            if (wb_op_reg == OP_WEIGHT)
            begin
                for (int i = 0; i < BURST_COUNT - 1; i++)
                    if (fire[i])
                        burst_reg[i] <= prod_reg[39:16];
                if (fire[BURST_COUNT-1])
                begin
                    burst_reg[BURST_COUNT-1] <= vel_reg;
                    tail_reg                 <= vel_reg;
                end
            end

            // Envelope decay
            if (wb_op_reg == OP_DEC0 || wb_op_reg == OP_DEC1 ||
                wb_op_reg == OP_DEC2 || wb_op_reg == OP_DEC3)
                burst_reg[2'(wb_op_reg - OP_DEC0)] <= prod_reg[47:24];
            if (wb_op_reg == OP_TAILD)
                tail_reg <= prod_reg[47:24];

            // Filter output, history shift, idle check
            if (cmd.op == OP_YOUT)
            begin
                hist_reg[1] <= hist_reg[0];
                hist_reg[0] <= x0_reg;
                hist_reg[3] <= hist_reg[2];
                hist_reg[2] <= sat32(y_shift);
                count_reg   <= count_inc;
                if (count_inc > CNT_W'(3) && sum_reg <= QUIET_LIMIT &&
                    SUM_W'(tail_reg) <= QUIET_LIMIT)
                    sounding_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hv_reg     <= hit_velocity;
            accent_reg <= accent;
            noise_reg  <= noise_sample;
            if (!func)
            begin
                res_audio_reg  <= '0;
                res_active_reg <= 1'b0;
            end
        end
        if (wb_op_reg == OP_TRIG_MUL)
            p_reg <= prod_reg[31:0];

        // Envelope sum
        if (cmd.op == OP_WEIGHT)
            sum_reg <= '0;
        else if (cmd.op == OP_DEC0 || cmd.op == OP_DEC1 ||
                 cmd.op == OP_DEC2 || cmd.op == OP_DEC3)
            sum_reg <= sum_reg + SUM_W'(burst_reg[2'(cmd.op - OP_DEC0)]);
        else if (wb_op_reg == OP_TAILW)
            sum_reg <= sum_reg + SUM_W'(prod_reg[38:16]);

        // Modulated noise into the filter
        if (wb_op_reg == OP_NOISE)
            x0_reg <= sat32(prod_ext >>> 15);

        // Biquad accumulate
        if (wb_op_reg == OP_FX2)
            acc_reg <= -prod_ext;
        else if (wb_op_reg == OP_FY1 || wb_op_reg == OP_FY2)
            acc_reg <= acc_reg - prod_ext;
        else if (wb_op_reg == OP_FX0)
            acc_reg <= acc_reg + prod_ext;

        if (cmd.op == OP_YOUT)
            y0_reg <= sat32(y_shift);

        // tanh interpolation
        if (cmd.op == OP_TANH)
        begin
            neg_reg  <= y0_reg[HIST_W-1];
            big_reg  <= |mag[31:23];
            base_reg <= (|mag[31:23]) ? TANH_MAX : seg_lo;
        end
        if (wb_op_reg == OP_TANH)
        begin
            res_audio_reg  <= neg_reg ? -$signed({1'b0, tanh_mag}) : $signed({1'b0, tanh_mag});
            res_active_reg <= sounding_reg;
        end

        // Output register
        if (cmd.emit)
        begin
            audio_reg  <= res_audio_reg;
            active_reg <= res_active_reg;
        end
    end

endmodule

/* hw/rtl/clap_noise_burst_voice_unit.sv */
`timescale 1ns / 1ps

// Clap drum voice.
// Input channel (in_valid / in_stall): func = 1 is a trigger that latches
// hit_velocity and accent and restarts the voice; func = 0 is a sample tick
// carrying noise_sample. A trigger gives no result, each tick gives one
// result (audio_out, voice_active) on the output channel (out_valid /
// out_stall). Configuration: cfg_valid / cfg_ready with cfg_index and
// cfg_data, always ready. The user must see that it is written only while
// the voice has no item in work; the block itself does not enforce this.
// One item at a time. A sounding tick runs 17 steps, OP_WEIGHT to OP_FINISH,
// between accept and output load; an idle tick goes straight to output load.
// in_stall is high while an item is in work or its result waits for the
// output register; a result waiting under out_stall holds, and a new item
// may be taken meanwhile.
// Reset: configuration takes its default values, voice idle, output empty.
module clap_noise_burst_voice_unit
#(
    parameter int COEF_WIDTH = cnb_pkg::COEF_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [15:0]                    hit_velocity,
    input  logic                           accent,
    input  logic signed [15:0]             noise_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             audio_out,
    output logic                           voice_active,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cnb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cnb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cnb_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cnb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    cnb_dp #(.COEF_WIDTH(COEF_WIDTH)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (func),
        .hit_velocity (hit_velocity),
        .accent       (accent),
        .noise_sample (noise_sample),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .audio_out    (audio_out),
        .voice_active (voice_active)
    );

endmodule
